// ===== sv/clipped_rectangle_draw_engine_defines.svh =====
// Assertion macros shared by the draw engine RTL.
`ifndef CLIPPED_RECTANGLE_DRAW_ENGINE_DEFINES_SVH
`define CLIPPED_RECTANGLE_DRAW_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define CRDE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge outside reset.
`define CRDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/crde_pkg.sv =====
// Constants and codes of the clipped rectangle draw engine.
package crde_pkg;

  localparam int SCR_BITS   = 12;
  localparam int COLOR_BITS = 8;
  localparam int OP_BITS    = 2;
  localparam int REG_BITS   = 2;

  localparam logic [OP_BITS-1:0] OP_FILL    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_OUTLINE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_STEP    = 2'd2;

  localparam logic [REG_BITS-1:0] REG_FRAME_BASE    = 2'd0;
  localparam logic [REG_BITS-1:0] REG_SCREEN_WIDTH  = 2'd1;
  localparam logic [REG_BITS-1:0] REG_SCREEN_HEIGHT = 2'd2;

  localparam logic [31:0]         FRAME_BASE_RESET    = 32'h000A_0000;
  localparam logic [SCR_BITS-1:0] SCREEN_WIDTH_RESET  = 12'd320;
  localparam logic [SCR_BITS-1:0] SCREEN_HEIGHT_RESET = 12'd200;

endpackage

// ===== sv/clipped_rectangle_draw_engine.sv =====
// Clipped rectangle fill and outline engine: a framebuffer write per active step beat.
// A step beat's write is registered and shows on the master side in the next cycle.
// Throughput: one input beat per cycle unless m_tready stalls a held write; the output
// register frees on the same cycle it is taken, so the clipping and cursor logic runs
// one beat per clock. Reset: synchronous active-high rst idles the engine, drops any
// pending write and restores frame_base 0xA0000, screen_width 320, screen_height 200.
module clipped_rectangle_draw_engine #(
  parameter int COORD_BITS = 16,
  parameter int ADDR_BITS  = 32
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               s_tvalid,
  output logic                                               s_tready,
  // rect_x, rect_y, rect_w, rect_h, pixel_color
  input  logic [((4*COORD_BITS+crde_pkg::COLOR_BITS+7)/8)*8-1:0] s_tdata,
  // operation
  input  logic [crde_pkg::OP_BITS-1:0]                       s_tuser,
  output logic                                               m_tvalid,
  input  logic                                               m_tready,
  // write_address, write_color
  output logic [((ADDR_BITS+crde_pkg::COLOR_BITS+7)/8)*8-1:0] m_tdata,
  // last_write
  output logic                                               m_tlast,
  input  logic                                               psel,
  input  logic                                               penable,
  input  logic                                               pwrite,
  input  logic [3:0]                                         paddr,
  input  logic [31:0]                                        pwdata,
  output logic [31:0]                                        prdata,
  output logic                                               pready
);
  import crde_pkg::*;

  `include "clipped_rectangle_draw_engine_defines.svh"

  localparam int CW = COORD_BITS + 2;
  localparam int OW = ((ADDR_BITS + COLOR_BITS + 7) / 8) * 8;
  localparam int PW = 2 * SCR_BITS;
  localparam int SW = (ADDR_BITS > PW) ? ADDR_BITS : PW;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_FILL    = 2'd1;
  localparam logic [1:0] MODE_OUTLINE = 2'd2;

  localparam logic signed [CW-1:0] ONE  = 1;
  localparam logic signed [CW-1:0] ZERO = 0;

  typedef struct packed {
    logic signed [CW-1:0] col_lo;
    logic signed [CW-1:0] col_hi;
    logic signed [CW-1:0] row_lo;
    logic signed [CW-1:0] row_hi;
    logic                 top_in;
    logic                 bot_in;
    logic                 left_in;
    logic                 right_in;
  } bounds_t;

  logic [31:0]          frame_base;
  logic [SCR_BITS-1:0]  screen_width;
  logic [SCR_BITS-1:0]  screen_height;

  logic [1:0]           run_mode, run_mode_next;
  logic                 outline_pass, outline_pass_next;
  logic                 edge_select, edge_select_next;
  logic signed [CW-1:0] cursor_column, cursor_column_next;
  logic signed [CW-1:0] cursor_row, cursor_row_next;
  logic signed [CW-1:0] saved_left, saved_top, saved_right, saved_bottom;
  logic [COLOR_BITS-1:0] saved_color;
  logic [31:0]          lat_base;
  logic [SCR_BITS-1:0]  lat_w;
  bounds_t              bnd;

  logic [ADDR_BITS-1:0]  out_addr;
  logic [COLOR_BITS-1:0] out_color;
  logic                  out_last;

  logic                 in_fire, is_start, is_step, emit;
  logic signed [CW-1:0] in_x, in_y, in_w, in_h, in_right, in_bottom, scr_w, scr_h;
  logic signed [CW-1:0] in_col_end, in_row_end;
  bounds_t              new_bnd, b;
  logic                 go_rows;
  logic signed [CW-1:0] emit_col, emit_row;
  logic [PW-1:0]        prod;
  logic [SW-1:0]        addr_sum;

  assign pready   = 1'b1;
  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;
  assign is_start = in_fire && (s_tuser == OP_FILL || s_tuser == OP_OUTLINE);
  assign is_step  = in_fire && s_tuser == OP_STEP;
  assign emit     = is_step && run_mode != MODE_IDLE;

  always_comb begin
    in_x       = CW'($signed(s_tdata[COORD_BITS-1:0]));
    in_y       = CW'($signed(s_tdata[2*COORD_BITS-1:COORD_BITS]));
    in_w       = CW'($signed(s_tdata[3*COORD_BITS-1:2*COORD_BITS]));
    in_h       = CW'($signed(s_tdata[4*COORD_BITS-1:3*COORD_BITS]));
    scr_w      = CW'(screen_width);
    scr_h      = CW'(screen_height);
    in_col_end = in_x + in_w;
    in_row_end = in_y + in_h;
    in_right   = in_col_end - ONE;
    in_bottom  = in_row_end - ONE;
    new_bnd.col_lo   = (in_x < ZERO) ? ZERO : in_x;
    new_bnd.col_hi   = (in_col_end > scr_w) ? scr_w : in_col_end;
    new_bnd.row_lo   = (in_y < ZERO) ? ZERO : in_y;
    new_bnd.row_hi   = (in_row_end > scr_h) ? scr_h : in_row_end;
    new_bnd.top_in   = in_y >= ZERO && in_y < scr_h;
    new_bnd.bot_in   = in_bottom >= ZERO && in_bottom < scr_h;
    new_bnd.left_in  = in_x >= ZERO && in_x < scr_w;
    new_bnd.right_in = in_right >= ZERO && in_right < scr_w;
    b = is_start ? new_bnd : bnd;
  end

  always_comb begin
    run_mode_next      = run_mode;
    outline_pass_next  = outline_pass;
    edge_select_next   = edge_select;
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    go_rows            = 1'b0;
    if (is_start) begin
      run_mode_next      = (s_tuser == OP_FILL) ? MODE_FILL : MODE_OUTLINE;
      outline_pass_next  = 1'b0;
      edge_select_next   = 1'b0;
      cursor_column_next = new_bnd.col_lo;
      cursor_row_next    = new_bnd.row_lo;
    end else if (emit) begin
      if (run_mode == MODE_FILL) begin
        cursor_column_next = cursor_column + ONE;
      end else if (!edge_select) begin
        edge_select_next = 1'b1;
      end else begin
        edge_select_next = 1'b0;
        if (!outline_pass) begin
          cursor_column_next = cursor_column + ONE;
        end else begin
          cursor_row_next = cursor_row + ONE;
        end
      end
    end
    if (is_start || emit) begin
      if (run_mode_next == MODE_FILL) begin
        if (cursor_column_next >= b.col_hi) begin
          cursor_column_next = b.col_lo;
          cursor_row_next    = cursor_row_next + ONE;
        end
        if (b.col_lo >= b.col_hi || cursor_row_next >= b.row_hi) begin
          run_mode_next = MODE_IDLE;
        end
      end else if (run_mode_next == MODE_OUTLINE) begin
        if (!outline_pass_next) begin
          if (cursor_column_next >= b.col_hi || (!b.top_in && !b.bot_in)) begin
            go_rows = 1'b1;
          end else if (!edge_select_next && !b.top_in) begin
            edge_select_next = 1'b1;
          end else if (edge_select_next && !b.bot_in) begin
            edge_select_next   = 1'b0;
            cursor_column_next = cursor_column_next + ONE;
            if (cursor_column_next >= b.col_hi) begin
              go_rows = 1'b1;
            end
          end
        end
        if (go_rows) begin
          outline_pass_next = 1'b1;
          cursor_row_next   = b.row_lo;
          edge_select_next  = 1'b0;
        end
        if (outline_pass_next) begin
          if (cursor_row_next >= b.row_hi || (!b.left_in && !b.right_in)) begin
            run_mode_next = MODE_IDLE;
          end else if (!edge_select_next && !b.left_in) begin
            edge_select_next = 1'b1;
          end else if (edge_select_next && !b.right_in) begin
            edge_select_next = 1'b0;
            cursor_row_next  = cursor_row_next + ONE;
            if (cursor_row_next >= b.row_hi) begin
              run_mode_next = MODE_IDLE;
            end
          end
        end
      end
    end
  end

  always_comb begin
    if (run_mode == MODE_FILL) begin
      emit_col = cursor_column;
      emit_row = cursor_row;
    end else if (!outline_pass) begin
      emit_col = cursor_column;
      emit_row = edge_select ? saved_bottom : saved_top;
    end else begin
      emit_col = edge_select ? saved_right : saved_left;
      emit_row = cursor_row;
    end
    prod     = PW'(emit_row[SCR_BITS-1:0]) * PW'(lat_w);
    addr_sum = SW'(lat_base[ADDR_BITS-1:0]) + SW'(prod) + SW'(emit_col[SCR_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode      <= MODE_IDLE;
      outline_pass  <= 1'b0;
      edge_select   <= 1'b0;
      cursor_column <= '0;
      cursor_row    <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      run_mode      <= run_mode_next;
      outline_pass  <= outline_pass_next;
      edge_select   <= edge_select_next;
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_start) begin
      bnd          <= new_bnd;
      saved_left   <= in_x;
      saved_top    <= in_y;
      saved_right  <= in_right;
      saved_bottom <= in_bottom;
      saved_color  <= s_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
      lat_base     <= frame_base;
      lat_w        <= screen_width;
    end
    if (emit) begin
      out_addr  <= addr_sum[ADDR_BITS-1:0];
      out_color <= saved_color;
      out_last  <= run_mode_next == MODE_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base    <= FRAME_BASE_RESET;
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_FRAME_BASE:    frame_base    <= pwdata;
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[SCR_BITS-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[SCR_BITS-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FRAME_BASE:    prdata = frame_base;
      REG_SCREEN_WIDTH:  prdata = 32'(screen_width);
      REG_SCREEN_HEIGHT: prdata = 32'(screen_height);
      default:           prdata = '0;
    endcase
  end

  assign m_tdata = OW'({out_color, out_addr});
  assign m_tlast = out_last;

  `CRDE_ASSERT_IMPLY(a_fill_cursor, clk, rst, run_mode == MODE_FILL,
    cursor_column >= bnd.col_lo && cursor_column < bnd.col_hi && cursor_row < bnd.row_hi,
    "fill cursor left the clipped area")
  `CRDE_ASSERT_IMPLY(a_outline_cols, clk, rst, run_mode == MODE_OUTLINE && !outline_pass,
    cursor_column >= bnd.col_lo && cursor_column < bnd.col_hi, "outline column out of range")
  `CRDE_ASSERT_IMPLY(a_outline_rows, clk, rst, run_mode == MODE_OUTLINE && outline_pass,
    cursor_row >= bnd.row_lo && cursor_row < bnd.row_hi, "outline row out of range")
  `CRDE_ASSERT_NEXT(a_step_emits, clk, rst, emit, m_tvalid, "active step gave no write")

endmodule
